### src/glos_pkg.sv
// ----------------------------------------------------------------------------
// glos_pkg
// Shared widths, command codes and controller/datapath handshake structs
// for the grid line-of-sight core.
// ----------------------------------------------------------------------------
package glos_pkg;

   localparam int ROW_FIELD_W = 6;
   localparam int COL_FIELD_W = 8;
   localparam int COORD_W     = 8;   // internal coordinate width, rows widened
   localparam int DIFF_W      = COORD_W + 1;
   localparam int PROD_W      = 2 * COORD_W;
   localparam int SLOPE_W     = PROD_W + 1;
   localparam int FRAC_W      = PROD_W + 3;

   localparam int MAP_ROWS_DEFAULT = 64;
   localparam int MAP_COLS_DEFAULT = 256;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_SIGHT = 1'b1;

   typedef struct packed {
      logic take;       // latch query endpoints
      logic wr;         // write one map cell
      logic prep;       // register deltas, axis and direction
      logic mul1;       // half = major * minor
      logic mul2;       // frac = minor * minor
      logic init;       // first step of the walk
      logic step;       // test cell on the major axis, advance
      logic diag;       // test the cell entered on the minor axis
      logic set_vis;
      logic vis_val;
      logic load_out;
   } glos_cmd_type;

   typedef struct packed {
      logic adjacent;
      logic at_end;
      logic gt;
      logic blocked;
   } glos_sts_type;

endpackage

### src/glos_if.sv
// ----------------------------------------------------------------------------
// glos request / response channels
// Valid/ready channels carrying one map transaction and one sight result.
// ----------------------------------------------------------------------------
interface glos_req_if;
   logic                               valid;
   logic                               ready;
   logic                               command;
   logic [glos_pkg::ROW_FIELD_W-1:0]   row_a;
   logic [glos_pkg::COL_FIELD_W-1:0]   col_a;
   logic [glos_pkg::ROW_FIELD_W-1:0]   row_b;
   logic [glos_pkg::COL_FIELD_W-1:0]   col_b;
   logic                               cell_open;

   modport source (output valid, command, row_a, col_a, row_b, col_b, cell_open,
                   input ready);
   modport sink   (input valid, command, row_a, col_a, row_b, col_b, cell_open,
                   output ready);
endinterface

interface glos_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink   (input valid, visible, output ready);
endinterface

### src/glos_datapath.sv
// ----------------------------------------------------------------------------
// glos_datapath
// Map memory, endpoint registers, fixed-point walk and result registers.
// ----------------------------------------------------------------------------
module glos_datapath #(
   parameter int MAP_ROWS = glos_pkg::MAP_ROWS_DEFAULT,
   parameter int MAP_COLS = glos_pkg::MAP_COLS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  glos_pkg::glos_cmd_type           cmd,
   output glos_pkg::glos_sts_type           sts,
   input  logic [glos_pkg::ROW_FIELD_W-1:0] req_row_a,
   input  logic [glos_pkg::COL_FIELD_W-1:0] req_col_a,
   input  logic [glos_pkg::ROW_FIELD_W-1:0] req_row_b,
   input  logic [glos_pkg::COL_FIELD_W-1:0] req_col_b,
   input  logic                             req_cell_open,
   output logic                             rsp_visible
);

   localparam int CW     = glos_pkg::COORD_W;
   localparam int DEPTH  = MAP_ROWS * MAP_COLS;
   localparam int ADDR_W = $clog2(DEPTH);

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [CW-1:0] r,
                                                   input logic [CW-1:0] c);
      return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAP_COLS)) + ADDR_W'(c);
   endfunction

   function automatic logic in_map(input logic [CW-1:0] r, input logic [CW-1:0] c);
      return ({1'b0, r} < (CW+1)'(MAP_ROWS)) && ({1'b0, c} < (CW+1)'(MAP_COLS));
   endfunction

   logic mem_ff [DEPTH];

   logic [CW-1:0] ra_ff, ca_ff, rb_ff, cb_ff;
   logic          col_maj_ff, straight_ff, maj_neg_ff, min_neg_ff;
   logic [CW-1:0] amaj_ff, amin_ff, maj_ff, min_ff, maj_end_ff;
   logic [CW-1:0] maj_in, min_in;
   logic [glos_pkg::PROD_W-1:0]         half_ff;
   logic [glos_pkg::SLOPE_W-1:0]        slope_ff;
   logic signed [glos_pkg::FRAC_W-1:0]  frac_ff, frac_in;
   logic          q_ff, inr_ff, chk_ff, blocked_ff, blocked_in;
   logic          vis_ff, out_vis_ff;

   // prep-cycle decode of latched endpoints
   logic signed [glos_pkg::DIFF_W-1:0] dr, dc;
   logic [CW-1:0] ar, ac;
   logic          col_maj, straight;

   assign dr = $signed({1'b0, rb_ff}) - $signed({1'b0, ra_ff});
   assign dc = $signed({1'b0, cb_ff}) - $signed({1'b0, ca_ff});
   assign ar = CW'((dr < 0) ? -dr : dr);
   assign ac = CW'((dc < 0) ? -dc : dc);
   assign col_maj = (ac >= ar);
   // knight offsets test just their first orthogonal cell: same as a straight run
   assign straight = (dr == 0) || (dc == 0) || ((ac == CW'(1)) && (ar == CW'(2)))
                     || ((ar == CW'(1)) && (ac == CW'(2)));

   // walk arithmetic
   logic signed [glos_pkg::FRAC_W-1:0] half_s, full_s, f_sum;
   logic [CW-1:0] maj_adv, min_adv;
   logic          eq0, gt, eq;

   assign half_s  = $signed({3'b000, half_ff});
   assign full_s  = $signed({2'b00, half_ff, 1'b0});
   assign f_sum   = frac_ff + $signed({2'b00, slope_ff});
   assign maj_adv = maj_neg_ff ? maj_ff - CW'(1) : maj_ff + CW'(1);
   assign min_adv = min_neg_ff ? min_ff - CW'(1) : min_ff + CW'(1);
   assign eq0     = !straight_ff && (frac_ff == half_s);
   assign gt      = !straight_ff && (f_sum > half_s);
   assign eq      = !straight_ff && (f_sum == half_s);

   always_comb begin
      maj_in  = maj_ff;
      min_in  = min_ff;
      frac_in = frac_ff;
      if (cmd.prep) begin
         maj_in = col_maj ? ca_ff : ra_ff;
         min_in = col_maj ? ra_ff : ca_ff;
      end else if (cmd.mul2) begin
         frac_in = $signed(glos_pkg::FRAC_W'(amin_ff * amin_ff));
      end else if (cmd.init) begin
         maj_in = maj_adv;
         if (eq0) begin
            min_in  = min_adv;
            frac_in = frac_ff - full_s;
         end
      end else if (cmd.step) begin
         if (gt || eq) begin
            min_in  = min_adv;
            frac_in = f_sum - full_s;
         end else begin
            frac_in = f_sum;
         end
         if (!gt) begin
            maj_in = maj_adv;
         end
      end else if (cmd.diag) begin
         maj_in = maj_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         ra_ff <= CW'(req_row_a);
         ca_ff <= CW'(req_col_a);
         rb_ff <= CW'(req_row_b);
         cb_ff <= CW'(req_col_b);
      end
      if (cmd.prep) begin
         col_maj_ff  <= col_maj;
         straight_ff <= straight;
         amaj_ff     <= col_maj ? ac : ar;
         amin_ff     <= col_maj ? ar : ac;
         maj_neg_ff  <= col_maj ? (dc < 0) : (dr < 0);
         min_neg_ff  <= col_maj ? (dr < 0) : (dc < 0);
         maj_end_ff  <= col_maj ? cb_ff : rb_ff;
      end
      if (cmd.mul1) begin
         half_ff <= glos_pkg::PROD_W'(amaj_ff * amin_ff);
      end
      if (cmd.mul2) begin
         slope_ff <= {glos_pkg::PROD_W'(amin_ff * amin_ff), 1'b0};
      end
      maj_ff  <= maj_in;
      min_ff  <= min_in;
      frac_ff <= frac_in;
      if (cmd.set_vis) begin
         vis_ff <= cmd.vis_val;
      end
      if (cmd.load_out) begin
         out_vis_ff <= vis_ff;
      end
   end

   // map memory: one write port, one registered read port
   logic [CW-1:0] rd_row, rd_col;
   assign rd_row = col_maj_ff ? min_ff : maj_ff;
   assign rd_col = col_maj_ff ? maj_ff : min_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr && in_map(CW'(req_row_a), CW'(req_col_a))) begin
         mem_ff[cell_addr(CW'(req_row_a), CW'(req_col_a))] <= req_cell_open;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= mem_ff[cell_addr(rd_row, rd_col)];
      inr_ff <= in_map(rd_row, rd_col);
   end

   // previous cycle's read lands here; a wall or off-map cell blocks the line
   assign blocked_in = blocked_ff || (chk_ff && !(inr_ff && q_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff     <= 1'b0;
         blocked_ff <= 1'b0;
      end else begin
         chk_ff     <= cmd.step || cmd.diag;
         blocked_ff <= cmd.init ? 1'b0 : blocked_in;
      end
   end

   assign sts.adjacent = (ar < CW'(2)) && (ac < CW'(2));
   assign sts.at_end   = (maj_ff == maj_end_ff);
   assign sts.gt       = gt;
   assign sts.blocked  = blocked_in;
   assign rsp_visible  = out_vis_ff;

endmodule

### src/glos_ctrl.sv
// ----------------------------------------------------------------------------
// glos_ctrl
// Sequencer: accepts transactions, steps the walk, owns the response valid.
// ----------------------------------------------------------------------------
module glos_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  glos_pkg::glos_sts_type sts,
   output glos_pkg::glos_cmd_type cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PREP  = 4'd1;
   localparam logic [3:0] S_MUL1  = 4'd2;
   localparam logic [3:0] S_MUL2  = 4'd3;
   localparam logic [3:0] S_INIT  = 4'd4;
   localparam logic [3:0] S_MAIN  = 4'd5;
   localparam logic [3:0] S_DIAG  = 4'd6;
   localparam logic [3:0] S_DRAIN = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command == glos_pkg::CMD_SIGHT) begin
                  cmd.take = 1'b1;
                  state_in = S_PREP;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            if (sts.adjacent) begin
               cmd.set_vis = 1'b1;
               cmd.vis_val = 1'b1;
               state_in    = S_RESP;
            end else begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_INIT;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_MAIN;
         end
         S_MAIN: begin
            if (sts.blocked) begin
               cmd.set_vis = 1'b1;
               state_in    = S_RESP;
            end else if (sts.at_end) begin
               state_in = S_DRAIN;
            end else begin
               cmd.step = 1'b1;
               state_in = sts.gt ? S_DIAG : S_MAIN;
            end
         end
         S_DIAG: begin
            if (sts.blocked) begin
               cmd.set_vis = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.diag = 1'b1;
               state_in = S_MAIN;
            end
         end
         S_DRAIN: begin
            cmd.set_vis = 1'b1;
            cmd.vis_val = !sts.blocked;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/grid_line_of_sight_core.sv
// ----------------------------------------------------------------------------
// grid_line_of_sight_core
// Line-of-sight queries over a one-bit open/wall grid map.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one transaction per valid/ready handshake. command 0
//   stores cell_open at (row_a, col_a); writes outside the map are dropped
//   and give no response. command 1 asks whether the line from (row_a,
//   col_a) to (row_b, col_b) passes only open cells; it returns one visible
//   bit on rsp_bus. Cells must be written before a query reads them.
//   Timing: a write leaves the core idle. Identical or adjacent endpoints
//   go from the prep state straight to the response state. Other queries
//   pass the prep, mul1, mul2 and init setup states, then walk the line
//   with one map read per cycle on the single read port, then finish
//   in the drain and response states, or sooner when a wall ends the walk.
//   One query is worked at a time; req_bus.ready is high only while idle.
//   The result sits in an output register, so a new transaction is taken
//   while rsp_bus stalls; a second result waits until the first is taken.
//   Reset (synchronous) clears control state only; map contents persist.
// ----------------------------------------------------------------------------
module grid_line_of_sight_core #(
   parameter int MAP_ROWS = glos_pkg::MAP_ROWS_DEFAULT,
   parameter int MAP_COLS = glos_pkg::MAP_COLS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   glos_req_if.sink  req_bus,
   glos_rsp_if.source rsp_bus
);

   glos_pkg::glos_cmd_type cmd;
   glos_pkg::glos_sts_type sts;

   glos_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   glos_datapath #(
      .MAP_ROWS (MAP_ROWS),
      .MAP_COLS (MAP_COLS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_row_a     (req_bus.row_a),
      .req_col_a     (req_bus.col_a),
      .req_row_b     (req_bus.row_b),
      .req_col_b     (req_bus.col_b),
      .req_cell_open (req_bus.cell_open),
      .rsp_visible   (rsp_bus.visible)
   );

`ifndef SYNTHESIS
   // a query transaction makes the core busy on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.command == glos_pkg::CMD_SIGHT)
      |=> !req_bus.ready)
      else $error("core still ready after taking a query");

   // a map write never stalls the request channel
   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.command == glos_pkg::CMD_WRITE)
      |=> req_bus.ready)
      else $error("core busy after a map write");

   // output register is loaded only when its previous result is gone
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("result overwritten while pending");

   // sequencer issues at most one datapath operation per cycle
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.prep, cmd.mul1, cmd.mul2, cmd.init, cmd.step, cmd.diag}))
      else $error("overlapping datapath commands");
`endif

endmodule
